>>> rtl/core/gll_pkg.sv
// Shared types, constants and table builders for the log luminance encoder.
`default_nettype none

package gll_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned BRIGHT_W = 16;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_GAMMA  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 1'b1;

  localparam logic [CFG_W-1:0]    GAMMA_DEFAULT = 16'd9011;
  localparam logic [BRIGHT_W-1:0] NO_BRIGHTNESS = 16'h8000;
  localparam logic [63:0]         LN2_Q32       = 64'd2977044472;

  localparam int unsigned NSH_W  = 4;
  localparam int unsigned ROM_W  = 17;
  localparam int unsigned LN2_W  = 20;
  localparam int unsigned D_W    = 21;
  localparam int unsigned G_W    = CFG_W + 1;
  localparam int unsigned P_W    = D_W + G_W;
  localparam int unsigned BS_W   = 11;
  localparam int unsigned Q_W    = P_W + BS_W;
  localparam int unsigned OFF_SH = 20;
  localparam int unsigned RND_SH = 28;

  typedef logic [LN2_W-1:0] ln2_tab_t [16];

  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic logic [ROM_W-1:0] log_rom_entry(input int unsigned m,
                                                     input int unsigned tab_bits);
    logic [63:0] den;
    logic [63:0] t;
    logic [63:0] t2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] twice;
    logic [63:0] r;
    logic [63:0] ent;
    den  = (64'd1 << (tab_bits + 1)) + 64'(m);
    t    = udiv64(64'(m) << 32, den);
    t2   = (t * t) >> 32;
    term = t;
    sum  = t;
    for (int k = 1; k < 24; k++) begin
      term = (term * t2) >> 32;
      sum  = sum + udiv64(term, 64'(2 * k + 1));
    end
    twice = sum << 1;
    r     = (twice > LN2_Q32) ? 64'd0 : (LN2_Q32 - twice);
    ent   = (r + 64'd32768) >> 16;
    return ROM_W'(64'd0 - ent);
  endfunction

  function automatic ln2_tab_t ln2_table();
    ln2_tab_t tab;
    logic [63:0] v;
    for (int n = 0; n < 16; n++) begin
      v      = (64'(n) * LN2_Q32 + 64'd32768) >> 16;
      tab[n] = LN2_W'(v);
    end
    return tab;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/gll_in_if.sv
// Sample channel: valid/ready handshake carrying one gray sample word.
`default_nettype none

interface gll_in_if
  import gll_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;
  logic                line_end;

  modport source (output valid, output sample, output line_end, input ready);
  modport sink   (input valid, input sample, input line_end, output ready);
endinterface

`default_nettype wire

>>> rtl/core/gll_out_if.sv
// Result channel: valid/ready handshake carrying one brightness word.
`default_nettype none

interface gll_out_if
  import gll_pkg::*;
;
  logic                       valid;
  logic                       ready;
  logic signed [BRIGHT_W-1:0] brightness;
  logic                       invalid;
  logic                       line_end_out;

  modport source (output valid, output brightness, output invalid, output line_end_out,
                  input ready);
  modport sink   (input valid, input brightness, input invalid, input line_end_out,
                  output ready);
endinterface

`default_nettype wire

>>> rtl/core/gray16_log_luminance_encode.sv
// Log luminance encoder for 16-bit gray samples: top level.
// Takes one sample word per cycle unless the full pipeline is stalled, and returns one
// brightness word per sample. Each accepted sample passes through the seven register
// stages in order and leaves from the output register. The seven register stages are:
// input register with leading-zero count, normalise and ROM read (2^LOG_TABLE_BITS
// entries, registered), log subtract, gamma multiply, offset add, scale multiply, and
// round/saturate into the output register. Each stage holds only when its successor is
// full and stalled, so bubbles are squeezed out and input stays open while any stage has
// room; only a full pipeline behind a stalled result blocks the input.
// A zero sample yields -32768 with invalid set; gamma zero selects 9011 (about 2.2).
`default_nettype none

module gray16_log_luminance_encode
  import gll_pkg::*;
#(
  parameter int unsigned LOG_TABLE_BITS = 11,
  parameter int unsigned BRIGHT_SCALE   = 128
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  gll_in_if.sink                    in_ch,
  gll_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  localparam int unsigned NSTG = 7;
  localparam int unsigned R_W  = Q_W - RND_SH;

  localparam ln2_tab_t LN2_TAB = ln2_table();
  localparam logic [BS_W-1:0]     BS_U     = BS_W'(BRIGHT_SCALE);
  localparam logic [Q_W-1:0]      RND_HALF = Q_W'(1) << (RND_SH - 1);
  localparam logic signed [R_W-1:0] SAT_HI = R_W'(32767);
  localparam logic signed [R_W-1:0] SAT_LO = -SAT_HI;

  logic [CFG_W-1:0] gamma_eff_r;
  logic [CFG_W-1:0] offset_r;

  logic [NSTG:1]   v_r;
  logic [NSTG+1:1] adv;

  logic [SAMPLE_W-1:0] s1_r;
  logic [NSH_W-1:0]    nsh1_r, nsh2_r;
  logic                zero1_r, zero2_r, zero3_r, zero4_r, zero5_r, zero6_r;
  logic                le1_r, le2_r, le3_r, le4_r, le5_r, le6_r;

  logic [NSH_W-1:0]        lz;
  logic [SAMPLE_W-1:0]     norm;
  logic signed [ROM_W-1:0] rom_q;

  logic signed [D_W-1:0] d3_r, d3_nxt;
  logic signed [P_W-1:0] prod4_r, prod4_nxt;
  logic signed [P_W-1:0] p5_r, p5_nxt;
  logic signed [Q_W-1:0] q6_r, q6_nxt;
  logic [Q_W-1:0]        rnd_add;
  logic signed [Q_W-1:0] qr;
  logic signed [R_W-1:0] r;

  logic signed [BRIGHT_W-1:0] bright_r, bright_nxt;
  logic                       inval_r;
  logic                       le7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_eff_r <= GAMMA_DEFAULT;
      offset_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GAMMA: begin
          gamma_eff_r <= (cfg_data == '0) ? GAMMA_DEFAULT : cfg_data;
        end
        CFG_OFFSET: begin
          offset_r <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    adv[NSTG+1] = out_ch.ready;
    for (int i = NSTG; i >= 1; i--) begin
      adv[i] = !v_r[i] || adv[i+1];
    end
  end

  assign in_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[1]) begin
        v_r[1] <= in_ch.valid;
      end
      for (int i = 2; i <= NSTG; i++) begin
        if (adv[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  always_comb begin
    lz = NSH_W'(15);
    for (int i = 0; i < SAMPLE_W; i++) begin
      if (in_ch.sample[i]) begin
        lz = NSH_W'(15 - i);
      end
    end
  end

  assign norm = s1_r << nsh1_r;

  gll_log_rom #(
    .TAB_BITS (LOG_TABLE_BITS)
  ) u_rom (
    .clk    (clk),
    .en     (adv[2]),
    .addr   (norm[SAMPLE_W-2 -: LOG_TABLE_BITS]),
    .data_r (rom_q)
  );

  assign d3_nxt = $signed({{(D_W-ROM_W){rom_q[ROM_W-1]}}, rom_q})
                - $signed({{(D_W-LN2_W){1'b0}}, LN2_TAB[nsh2_r]});

  assign prod4_nxt = d3_r * $signed({1'b0, gamma_eff_r});

  assign p5_nxt = prod4_r
                + $signed({{(P_W-CFG_W-OFF_SH){offset_r[CFG_W-1]}}, offset_r, OFF_SH'(0)});

  assign q6_nxt = p5_r * $signed({1'b0, BS_U});

  always_comb begin
    rnd_add = q6_r[Q_W-1] ? (RND_HALF - Q_W'(1)) : RND_HALF;
    qr      = q6_r + $signed(rnd_add);
    r       = qr[Q_W-1:RND_SH];
    if (zero6_r) begin
      bright_nxt = NO_BRIGHTNESS;
    end else if (r > SAT_HI) begin
      bright_nxt = SAT_HI[BRIGHT_W-1:0];
    end else if (r < SAT_LO) begin
      bright_nxt = SAT_LO[BRIGHT_W-1:0];
    end else begin
      bright_nxt = r[BRIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_r    <= in_ch.sample;
      nsh1_r  <= lz;
      zero1_r <= (in_ch.sample == '0);
      le1_r   <= in_ch.line_end;
    end
    if (adv[2]) begin
      nsh2_r  <= nsh1_r;
      zero2_r <= zero1_r;
      le2_r   <= le1_r;
    end
    if (adv[3]) begin
      d3_r    <= d3_nxt;
      zero3_r <= zero2_r;
      le3_r   <= le2_r;
    end
    if (adv[4]) begin
      prod4_r <= prod4_nxt;
      zero4_r <= zero3_r;
      le4_r   <= le3_r;
    end
    if (adv[5]) begin
      p5_r    <= p5_nxt;
      zero5_r <= zero4_r;
      le5_r   <= le4_r;
    end
    if (adv[6]) begin
      q6_r    <= q6_nxt;
      zero6_r <= zero5_r;
      le6_r   <= le5_r;
    end
    if (adv[7]) begin
      bright_r <= bright_nxt;
      inval_r  <= zero6_r;
      le7_r    <= le6_r;
    end
  end

  assign out_ch.valid        = v_r[NSTG];
  assign out_ch.brightness   = bright_r;
  assign out_ch.invalid      = inval_r;
  assign out_ch.line_end_out = le7_r;

  a_invalid_code: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG] && inval_r) |-> (bright_r == NO_BRIGHTNESS))
    else $error("invalid word without no-brightness code");

  a_valid_code: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NSTG] && !inval_r) |-> (bright_r != NO_BRIGHTNESS))
    else $error("nonzero sample gave no-brightness code");

  a_log_sign: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[3] && !zero3_r) |-> (d3_r <= 0))
    else $error("normalised log above zero");

  a_gamma_set: assert property (@(posedge clk) disable iff (!rst_n)
    gamma_eff_r != '0)
    else $error("effective gamma is zero");

endmodule

`default_nettype wire

>>> rtl/core/gll_log_rom.sv
// Mantissa log ROM, contents built at elaboration, registered read.
`default_nettype none

module gll_log_rom
  import gll_pkg::*;
#(
  parameter int unsigned TAB_BITS = 11
) (
  input  wire logic                    clk,
  input  wire logic                    en,
  input  wire logic [TAB_BITS-1:0]     addr,
  output      logic signed [ROM_W-1:0] data_r
);

  localparam int unsigned DEPTH = 1 << TAB_BITS;

  logic signed [ROM_W-1:0] tab [DEPTH];

  for (genvar m = 0; m < DEPTH; m++) begin : g_ent
    localparam logic signed [ROM_W-1:0] ENTRY = log_rom_entry(m, TAB_BITS);
    assign tab[m] = ENTRY;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      data_r <= tab[addr];
    end
  end

endmodule

`default_nettype wire
